/* rtl/oas_pkg.sv */
// shared constants and types for the oversampled converter uart sender
`default_nettype none
package oas_pkg;
	localparam int SAMPLES_PER_BLOCK_DEF = 16;
	localparam int SAMPLE_BITS_DEF = 10;

	localparam int VALUE_W = 12;
	localparam int STOP_W = 3;
	localparam int PHASE_W = 5;
	localparam int BYTE_W = 8;
	localparam int PEND_W = 2;
	localparam int FIELD_W = 6;

	localparam logic [STOP_W-1:0] STOP_RESET = 3'd2;

	localparam logic [BYTE_W-1:0] TAG_HIGH = 8'h80;
	localparam logic [BYTE_W-1:0] TAG_LOW = 8'h40;

	localparam logic [PHASE_W-1:0] PHASE_START = 5'h00;
	localparam logic [PHASE_W-1:0] PHASE_LAST_DATA = 5'h08;
	localparam logic [PHASE_W-1:0] PHASE_TOP = 5'h0F;
	localparam logic [PHASE_W-1:0] PHASE_IDLE = 5'h10;

	localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
	localparam logic [PEND_W-1:0] PEND_LOW = 2'd1;
	localparam logic [PEND_W-1:0] PEND_BOTH = 2'd2;

	// transmitter status after the current item, seen by the averager and the top level
	typedef struct packed {
		logic pend_zero;
		logic line;
		logic busy;
	} tx_stat_t;
endpackage
`default_nettype wire

/* rtl/oas_ifs.sv */
// valid/ready channel interfaces for items, results and configuration
`default_nettype none
interface oas_item_if #(
	parameter int SAMPLE_BITS = oas_pkg::SAMPLE_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic                   func;
	logic [SAMPLE_BITS-1:0] sample_value;
	modport source (output valid, output func, output sample_value, input ready);
	modport sink (input valid, input func, input sample_value, output ready);
endinterface

interface oas_result_if;
	logic                          valid;
	logic                          ready;
	logic                          tx_line;
	logic                          tx_busy;
	logic                          block_done;
	logic [oas_pkg::VALUE_W-1:0]   block_value;
	modport source (output valid, output tx_line, output tx_busy, output block_done,
		output block_value, input ready);
	modport sink (input valid, input tx_line, input tx_busy, input block_done,
		input block_value, output ready);
endinterface

interface oas_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [oas_pkg::STOP_W-1:0]   data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/oas_avg.sv */
// sample accumulator with block completion
`default_nettype none
module oas_avg #(
	parameter int SAMPLES_PER_BLOCK = oas_pkg::SAMPLES_PER_BLOCK_DEF,
	parameter int SAMPLE_BITS = oas_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         step,
	input  wire logic                         func,
	input  wire logic [SAMPLE_BITS-1:0]       sample_value,
	input  wire oas_pkg::tx_stat_t            tx_stat,
	output logic                              done,
	output logic [oas_pkg::VALUE_W-1:0]       value
);
	localparam int SUM_W = SAMPLE_BITS + $clog2(SAMPLES_PER_BLOCK);
	localparam int CNT_W = $clog2(SAMPLES_PER_BLOCK + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SAMPLES_PER_BLOCK);

	logic [SUM_W-1:0]            sum_q, sum_a;
	logic [CNT_W-1:0]            count_q, count_a;
	logic [SUM_W+oas_pkg::VALUE_W-1:0] sum_ext;

	always_comb begin
		sum_a = sum_q;
		count_a = count_q;
		if (step && !func && count_q < CNT_FULL) begin
			sum_a = sum_q + SUM_W'(sample_value);
			count_a = count_q + CNT_W'(1);
		end
		done = step && (count_a >= CNT_FULL) && tx_stat.pend_zero;
		sum_ext = {{oas_pkg::VALUE_W{1'b0}}, sum_a};
		value = sum_ext[oas_pkg::VALUE_W+1:2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			count_q <= '0;
		end else if (done) begin
			sum_q <= '0;
			count_q <= '0;
		end else if (step) begin
			sum_q <= sum_a;
			count_q <= count_a;
		end
	end
endmodule
`default_nettype wire

/* rtl/oas_tx.sv */
// tagged two-byte uart transmitter, one bit period per baud tick
`default_nettype none
module oas_tx (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step,
	input  wire logic                          tick,
	input  wire logic [oas_pkg::STOP_W-1:0]    stop_bit_count,
	input  wire logic                          load,
	input  wire logic [oas_pkg::VALUE_W-1:0]   load_value,
	output oas_pkg::tx_stat_t                  stat,
	output logic [oas_pkg::VALUE_W-1:0]        held_value
);
	logic [oas_pkg::BYTE_W-1:0]  shift_q, shift_a;
	logic [oas_pkg::PHASE_W-1:0] phase_q, phase_a, phase_b;
	logic                        line_q, line_a;
	logic [oas_pkg::PEND_W-1:0]  pend_q, pend_a;
	logic [oas_pkg::VALUE_W-1:0] held_q;
	logic [oas_pkg::BYTE_W-1:0]  next_byte;

	always_comb begin
		shift_a = shift_q;
		phase_a = phase_q;
		line_a = line_q;
		pend_a = pend_q;
		phase_b = phase_q;
		if (pend_q == oas_pkg::PEND_BOTH)
			next_byte = oas_pkg::TAG_HIGH
				| oas_pkg::BYTE_W'(held_q[oas_pkg::VALUE_W-1:oas_pkg::FIELD_W]);
		else
			next_byte = oas_pkg::TAG_LOW | oas_pkg::BYTE_W'(held_q[oas_pkg::FIELD_W-1:0]);
		if (step && tick) begin
			if (phase_q < oas_pkg::PHASE_IDLE) begin
				line_a = shift_q[0];
				shift_a = {1'b1, shift_q[oas_pkg::BYTE_W-1:1]};
				// after the last data bit jump so that stop_bit_count periods remain
				if (phase_q == oas_pkg::PHASE_LAST_DATA)
					phase_b = oas_pkg::PHASE_TOP - oas_pkg::PHASE_W'(stop_bit_count);
				phase_a = phase_b + oas_pkg::PHASE_W'(1);
			end
			if (phase_a >= oas_pkg::PHASE_IDLE && pend_q != oas_pkg::PEND_NONE) begin
				pend_a = pend_q - oas_pkg::PEND_W'(1);
				shift_a = next_byte;
				phase_a = oas_pkg::PHASE_START;
				line_a = 1'b0;
			end
		end
		stat.pend_zero = (pend_a == oas_pkg::PEND_NONE);
		stat.line = line_a;
		stat.busy = (phase_a < oas_pkg::PHASE_IDLE);
		held_value = load ? load_value : held_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '1;
			phase_q <= oas_pkg::PHASE_IDLE;
			line_q <= 1'b1;
			pend_q <= oas_pkg::PEND_NONE;
			held_q <= '0;
		end else if (step) begin
			shift_q <= shift_a;
			phase_q <= phase_a;
			line_q <= line_a;
			pend_q <= load ? oas_pkg::PEND_BOTH : pend_a;
			held_q <= held_value;
		end
	end
endmodule
`default_nettype wire

/* rtl/oversampled_adc_uart_sender_top.sv */
// top level: input register, averager, transmitter and result register
// an accepted item is held in the input register, then its result in the result register
// throughput: one item per cycle, set by the state update between
//   the input register and the result register; back pressure from the result side
//   stalls the input register
// reset: arst_n clears sums, queue and transmitter (line idle high), stop count to 2
`default_nettype none
module oversampled_adc_uart_sender_top #(
	parameter int SAMPLES_PER_BLOCK = oas_pkg::SAMPLES_PER_BLOCK_DEF,
	parameter int SAMPLE_BITS = oas_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	oas_item_if.sink   item,
	oas_result_if.source result,
	oas_cfg_if.sink    cfg
);
	logic                        valid_s1;
	logic                        func_s1;
	logic [SAMPLE_BITS-1:0]      sample_s1;
	logic                        advance;
	logic [oas_pkg::STOP_W-1:0]  stop_q;
	oas_pkg::tx_stat_t           tx_stat;
	logic                        done;
	logic [oas_pkg::VALUE_W-1:0] avg_value;
	logic [oas_pkg::VALUE_W-1:0] held_value;
	logic                        res_valid_q;
	logic                        res_line_q;
	logic                        res_busy_q;
	logic                        res_done_q;
	logic [oas_pkg::VALUE_W-1:0] res_value_q;

	assign advance = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_q <= oas_pkg::STOP_RESET;
		end else if (cfg.valid) begin
			stop_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			func_s1 <= item.func;
			sample_s1 <= item.sample_value;
		end
	end

	oas_avg #(
		.SAMPLES_PER_BLOCK(SAMPLES_PER_BLOCK),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_avg (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.func(func_s1),
		.sample_value(sample_s1),
		.tx_stat(tx_stat),
		.done(done),
		.value(avg_value)
	);

	oas_tx u_tx (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.tick(func_s1),
		.stop_bit_count(stop_q),
		.load(done),
		.load_value(avg_value),
		.stat(tx_stat),
		.held_value(held_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_line_q <= tx_stat.line;
			res_busy_q <= tx_stat.busy;
			res_done_q <= done;
			res_value_q <= held_value;
		end
	end

	assign result.valid = res_valid_q;
	assign result.tx_line = res_line_q;
	assign result.tx_busy = res_busy_q;
	assign result.block_done = res_done_q;
	assign result.block_value = res_value_q;

	// a block completes only once the transmitter queue has drained
	a_done_needs_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> advance && tx_stat.pend_zero)
		else $error("block completed while bytes still queued");

	// an accepted transaction always lands in the input register
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> valid_s1)
		else $error("accepted transaction lost before the input register");

	// a stalled input register keeps its item
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(func_s1) && $stable(sample_s1))
		else $error("stalled item changed in the input register");

	// every result moved out of the input register is presented
	a_result_after_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid_q)
		else $error("result register missed a transaction");
endmodule
`default_nettype wire
